// ===== design/multi_voice_sample_mixer_assert.svh =====
// assertion macros for the sample mixer
`ifndef MULTI_VOICE_SAMPLE_MIXER_ASSERT_SVH
`define MULTI_VOICE_SAMPLE_MIXER_ASSERT_SVH
// implication checked at every clock edge outside reset
`define MVSM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%s failed", "label");
// implication checked in the cycle after the antecedent
`define MVSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%s failed", "label");
`endif

// ===== design/mvsm_pkg.sv =====
// shared constants, types and helpers for the sample mixer
`default_nettype none
package mvsm_pkg;
  localparam int EFFECT_VOICES = 8;
  localparam int NVOICES = EFFECT_VOICES + 1;
  localparam int VW = $clog2(NVOICES);
  localparam int SOUND_SLOTS = 16;
  localparam int HW = 4;
  localparam int SAMPLE_DEPTH = 65536;
  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int OUT_CHANNELS = 2;

  localparam logic [2:0] FN_TICK = 3'd0;
  localparam logic [2:0] FN_PLAY_SFX = 3'd1;
  localparam logic [2:0] FN_PLAY_MUSIC = 3'd2;
  localparam logic [2:0] FN_STOP_MUSIC = 3'd3;
  localparam logic [2:0] FN_WRITE_SAMPLE = 3'd4;
  localparam logic [2:0] FN_WRITE_DESC = 3'd5;
  localparam logic [2:0] FN_MUSIC_EN = 3'd6;

  localparam logic [1:0] REG_SFX_EN = 2'd0;
  localparam logic [1:0] REG_MUSIC_GAIN = 2'd1;
  localparam logic [1:0] REG_SFX_GAIN = 2'd2;

  typedef struct packed {
    logic [HW-1:0] sound;
    logic [16:0] pos;
    logic loop_en;
    logic active;
  } voice_t;

  // gain scale, truncated toward zero, gain clamped at unity
  function automatic logic signed [15:0] apply_gain(logic signed [15:0] s, logic [8:0] g);
    logic [8:0] gc;
    logic signed [25:0] p;
    logic [24:0] m;
    begin
      gc = (g > 9'd256) ? 9'd256 : g;
      p = s * $signed({1'b0, gc});
      m = p[25] ? 25'(-p) : p[24:0];
      m = m >> 8;
      apply_gain = p[25] ? -16'(m) : 16'(m);
    end
  endfunction

  function automatic logic signed [15:0] sat_add(logic signed [15:0] a, logic signed [15:0] b);
    logic signed [16:0] r;
    begin
      r = 17'(a) + 17'(b);
      if (r > 17'sd32767) sat_add = 16'sh7fff;
      else if (r < -17'sd32768) sat_add = 16'sh8000;
      else sat_add = r[15:0];
    end
  endfunction
endpackage
`default_nettype wire

// ===== design/mvsm_sample_ram.sv =====
// sample memory, one write port and one registered read port
`default_nettype none
module mvsm_sample_ram
  import mvsm_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [15:0]        rdata
);
  logic [15:0] mem [SAMPLE_DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/multi_voice_sample_mixer.sv =====
// top level of the sample mixer
// multi_voice_sample_mixer: mixes a looping music voice (voice 0) and eight effect
// voices into saturated stereo 16-bit frames. Sample words and sound descriptors are
// loaded through the input channel (func 4 and 5); a tick (func 0) yields one frame
// on the output channel, other functions produce nothing. One item is worked at a
// time. A tick visits the nine voices in turn through the single read port of the
// sample memory: an idle voice takes only the voice state read, a playing voice
// four steps (voice state read, address set-up, left word read, right word read).
// A tick also has a decode step before the voices and an emit step after them;
// other functions take only the decode step. A finished frame sits in an output
// register and the next item is taken while it waits; a following tick holds in
// its emit step until that register is free. Voice state lives in a small register
// file, written back once per voice visit; no clearing pass.
`default_nettype none
module multi_voice_sample_mixer
  import mvsm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         func,
  input  wire logic [3:0]         handle,
  input  wire logic [15:0]        addr,
  input  wire logic signed [15:0] sample,
  input  wire logic [15:0]        base,
  input  wire logic [16:0]        length,
  input  wire logic               stereo,
  input  wire logic               flag,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      left_out,
  output logic signed [15:0]      right_out,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OP = 3'd1;
  localparam logic [2:0] ST_VSTATE = 3'd2;
  localparam logic [2:0] ST_RDL = 3'd3;
  localparam logic [2:0] ST_RDR = 3'd4;
  localparam logic [2:0] ST_ACC = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  // configuration registers
  logic       sfx_enabled;
  logic [8:0] music_gain, sfx_gain;

  // voice state and descriptors
  voice_t      voices [NVOICES];
  logic [15:0] snd_base [SOUND_SLOTS];
  logic [16:0] snd_len [SOUND_SLOTS];
  logic        snd_stereo [SOUND_SLOTS];
  logic [SOUND_SLOTS-1:0] snd_valid;
  logic [HW-1:0] last_music;
  logic          music_on;

  // latched item
  logic [2:0]  r_func;
  logic [HW-1:0] r_handle;
  logic [15:0] r_addr, r_sample, r_base;
  logic [16:0] r_length;
  logic        r_stereo, r_flag;

  logic [2:0]    state;
  logic [VW-1:0] vidx;
  logic [16:0]   cur_pos;
  logic          cur_sc2;
  logic signed [15:0] acc_l, acc_r, word_l;
  logic [15:0]   rd_base;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != ST_IDLE);
  wire in_xfer = in_valid && !in_stall;
  wire out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sfx_enabled <= 1'b1;
      music_gain <= 9'd256;
      sfx_gain <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SFX_EN: sfx_enabled <= cfg_data[0];
        REG_MUSIC_GAIN: music_gain <= cfg_data[8:0];
        REG_SFX_GAIN: sfx_gain <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign ram_we = (state == ST_OP) && (r_func == FN_WRITE_SAMPLE);

  mvsm_sample_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (r_addr[AW-1:0]),
    .wdata (r_sample),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // current voice evaluation: end-of-sound handling, looping and position advance
  voice_t vs;
  logic [HW-1:0] vh;
  logic [16:0] vlen, vpos, pos_use;
  logic [17:0] pos_end;
  logic vsc2, vgo;
  voice_t v_after;
  always_comb begin
    vs = voices[vidx];
    vh = vs.sound;
    vlen = snd_len[vh];
    vsc2 = snd_stereo[vh];
    vpos = vs.pos;
    pos_end = 18'(vpos) + (vsc2 ? 18'd2 : 18'd1);
    v_after = vs;
    vgo = 1'b0;
    pos_use = vpos;
    if (vs.active && vh != '0) begin
      if (!snd_valid[vh]) v_after.active = 1'b0;
      else if (pos_end > 18'(vlen)) begin
        if (vs.loop_en && ((vsc2 ? 18'd2 : 18'd1) <= 18'(vlen))) begin
          pos_use = '0;
          vgo = 1'b1;
        end else v_after.active = 1'b0;
      end else vgo = 1'b1;
    end
    if (vgo) v_after.pos = pos_use + (vsc2 ? 17'd2 : 17'd1);
  end

  always_comb begin
    ram_raddr = rd_base[AW-1:0] + cur_pos[AW-1:0];
    if (state == ST_RDL) ram_raddr = rd_base[AW-1:0] + cur_pos[AW-1:0] + AW'(1);
  end

  // first idle effect slot
  logic [VW-1:0] free_slot;
  always_comb begin
    free_slot = VW'(1);
    for (int v = NVOICES - 1; v >= 1; v--)
      if (!voices[v].active) free_slot = VW'(v);
  end

  wire usable_h = (r_handle != '0) && snd_valid[r_handle];
  wire usable_lm = (last_music != '0) && snd_valid[last_music];
  wire [8:0] cur_gain = (vidx == '0) ? music_gain : sfx_gain;
  wire signed [15:0] word_r = cur_sc2 ? $signed(ram_rdata) : word_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      snd_valid <= '0;
      last_music <= '0;
      music_on <= 1'b1;
      vidx <= '0;
      for (int v = 0; v < NVOICES; v++) voices[v] <= '0;
    end else begin
      // the emit step reloads the output register in the cycle it drains
      if (out_xfer && state != ST_EMIT) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            r_func <= func; r_handle <= handle; r_addr <= addr; r_sample <= sample;
            r_base <= base; r_length <= length; r_stereo <= stereo; r_flag <= flag;
            state <= ST_OP;
          end
        end
        ST_OP: begin
          state <= (r_func == FN_TICK) ? ST_VSTATE : ST_IDLE;
          case (r_func)
            FN_TICK: begin
              acc_l <= '0; acc_r <= '0; vidx <= '0;
            end
            FN_PLAY_SFX: if (sfx_enabled && usable_h)
              voices[free_slot] <= '{sound: r_handle, pos: '0, loop_en: 1'b0, active: 1'b1};
            FN_PLAY_MUSIC: if (usable_h) begin
              last_music <= r_handle;
              voices[0] <= music_on ?
                  '{sound: r_handle, pos: '0, loop_en: 1'b1, active: 1'b1} : '0;
            end
            FN_STOP_MUSIC: begin
              voices[0] <= '0; last_music <= '0;
            end
            FN_WRITE_DESC: if (r_handle != '0) begin
              if (r_flag) begin
                snd_base[r_handle] <= r_base; snd_len[r_handle] <= r_length;
                snd_stereo[r_handle] <= r_stereo; snd_valid[r_handle] <= 1'b1;
              end else begin
                for (int v = 0; v < NVOICES; v++)
                  if (voices[v].sound == r_handle) voices[v] <= '0;
                if (last_music == r_handle) last_music <= '0;
                snd_valid[r_handle] <= 1'b0;
              end
            end
            FN_MUSIC_EN: begin
              music_on <= r_flag;
              if (!r_flag) voices[0] <= '0;
              else if (usable_lm)
                voices[0] <= '{sound: last_music, pos: '0, loop_en: 1'b1, active: 1'b1};
            end
            default: ;
          endcase
        end
        ST_VSTATE: begin
          // write back voice state, set up reads at the position used
          voices[vidx] <= v_after;
          cur_pos <= pos_use;
          cur_sc2 <= vsc2;
          rd_base <= snd_base[vh];
          if (vgo) state <= ST_ACC;
          else if (vidx == VW'(NVOICES - 1)) state <= ST_EMIT;
          else vidx <= vidx + VW'(1);
        end
        ST_ACC: state <= ST_RDL;     // left address applied
        ST_RDL: begin
          word_l <= ram_rdata;        // right address applied now
          state <= ST_RDR;
        end
        ST_RDR: begin
          acc_l <= sat_add(acc_l, apply_gain(word_l, cur_gain));
          if (OUT_CHANNELS >= 2) acc_r <= sat_add(acc_r, apply_gain(word_r, cur_gain));
          if (vidx == VW'(NVOICES - 1)) state <= ST_EMIT;
          else begin
            vidx <= vidx + VW'(1);
            state <= ST_VSTATE;
          end
        end
        ST_EMIT: if (!out_valid || out_stall == 1'b0) begin
          left_out <= acc_l; right_out <= acc_r;
          out_valid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `include "multi_voice_sample_mixer_assert.svh"
  `MVSM_ASSERT_IMP(a_stall_busy, state != ST_IDLE, in_stall)
  `MVSM_ASSERT_NEXT(a_emit_valid, state == ST_EMIT && !(out_valid && out_stall), out_valid)
  `MVSM_ASSERT_IMP(a_no_write_in_tick, state == ST_RDL || state == ST_RDR, !ram_we)
endmodule
`default_nettype wire
